### src/lis_pkg.sv
package lis_pkg;

   // Table geometry
   localparam int MAX_TAILS  = 1024;
   localparam int VALUE_BITS = 31;
   localparam int ADDR_BITS  = $clog2(MAX_TAILS);
   localparam int CNT_BITS   = $clog2(MAX_TAILS + 1);
   localparam int LEN_BITS   = 11;
   localparam int LEN_MAX    = (1 << LEN_BITS) - 1;

   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_TAILS);

   typedef struct packed {
      logic [30:0] element_value;
      logic        has_value;
      logic        end_of_sequence;
   } req_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] run_length;
      logic                sequence_done;
      logic                table_overflow;
   } rsp_type;

   // Microprogram steps
   typedef enum logic [2:0] {
      STEP_WAIT,
      STEP_BRANCH,
      STEP_SEARCH,
      STEP_UPDATE,
      STEP_RESULT
   } step_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_HAS_VALUE,
      COND_SEARCH_DONE,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     search;
      logic     update;
      logic     respond;
      cond_type cond;
      step_type jump;   // taken when cond holds
      step_type next;   // taken otherwise
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic has_value;
      logic search_done;
      logic rsp_free;
   } flags_type;

   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = '{req_ready: 1'b0, search: 1'b0, update: 1'b0, respond: 1'b0,
            cond: COND_ALWAYS, jump: STEP_WAIT, next: STEP_WAIT};
      unique case (step)
         STEP_WAIT: begin
            w.req_ready = 1'b1;
            w.cond      = COND_REQ;
            w.jump      = STEP_BRANCH;
            w.next      = STEP_WAIT;
         end
         STEP_BRANCH: begin
            w.cond = COND_HAS_VALUE;
            w.jump = STEP_SEARCH;
            w.next = STEP_RESULT;
         end
         STEP_SEARCH: begin
            w.search = 1'b1;
            w.cond   = COND_SEARCH_DONE;
            w.jump   = STEP_UPDATE;
            w.next   = STEP_SEARCH;
         end
         STEP_UPDATE: begin
            w.update = 1'b1;
            w.cond   = COND_ALWAYS;
            w.jump   = STEP_RESULT;
            w.next   = STEP_RESULT;
         end
         STEP_RESULT: begin
            w.respond = 1'b1;
            w.cond    = COND_RSP_FREE;
            w.jump    = STEP_WAIT;
            w.next    = STEP_RESULT;
         end
         default: begin
            w.cond = COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

   function automatic logic [LEN_BITS-1:0] len_sat(logic [CNT_BITS-1:0] count);
      if (32'(count) > 32'(LEN_MAX)) begin
         return LEN_BITS'(LEN_MAX);
      end
      return LEN_BITS'(count);
   endfunction

endpackage

### src/longest_increasing_subsequence.sv
// Streams one sequence element per req beat and returns one rsp beat per element with the
// running strictly-increasing LIS length, kept as a sorted table of pile tails in a
// single-port memory. After acceptance an element passes through the branch, search,
// update and result steps; the search makes at most ceil(log2(tails + 1)) binary-search
// probes, so at most 11 with 1024 tails, reading the tail memory once per cycle. An item
// without a value goes from the branch step straight to the result step. Each result is
// loaded into the output register once it is free; the next item is accepted after that,
// even while the previous result still waits on rsp_ready. end_of_sequence reports the
// final length and clears the table; once the table is full, longer elements are
// dropped and table_overflow stays set until the sequence ends.
module longest_increasing_subsequence (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lis_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lis_pkg::rsp_type rsp_data
);

   localparam int CB = lis_pkg::CNT_BITS;
   localparam int AB = lis_pkg::ADDR_BITS;
   localparam int VB = lis_pkg::VALUE_BITS;

   lis_pkg::ucode_type word;
   lis_pkg::flags_type flags;

   logic [VB-1:0] tail_mem [lis_pkg::MAX_TAILS];
   logic [VB-1:0] rd_data_ff;

   logic [VB-1:0] value_ff, value_in;
   logic          has_value_ff, has_value_in;
   logic          last_ff, last_in;
   logic [CB-1:0] lo_ff, lo_in;
   logic [CB-1:0] hi_ff, hi_in;
   logic [CB-1:0] mid_ff, mid_in;
   logic          pend_ff, pend_in;
   logic [CB-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lis_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          rsp_free;
   logic          respond;
   logic [CB-1:0] lo_n, hi_n, mid_n;
   logic [CB:0]   mid_sum;
   logic          search_done;
   logic          rd_en;
   logic          mem_we;
   logic          append;

   lis_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .word  (word)
   );

   assign req_ready = word.req_ready;
   assign accept    = req_valid && word.req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign respond   = word.respond && rsp_free;

   // fold in the probe returned last cycle, then pick the next probe
   always_comb begin
      lo_n = lo_ff;
      hi_n = hi_ff;
      if (pend_ff) begin
         if (rd_data_ff < value_ff) begin
            lo_n = mid_ff + CB'(1);
         end else begin
            hi_n = mid_ff;
         end
      end
      search_done = !(lo_n < hi_n);
      mid_sum     = {1'b0, lo_n} + {1'b0, hi_n};
      mid_n       = mid_sum[CB:1];
      rd_en       = word.search && !search_done;
   end

   // lo_ff equals the count when every tail is smaller
   assign append = (lo_ff == count_ff);
   assign mem_we = word.update && (!append || count_ff != lis_pkg::MAX_CNT);

   always_comb begin
      flags.req_valid   = req_valid;
      flags.has_value   = has_value_ff;
      flags.search_done = search_done;
      flags.rsp_free    = rsp_free;
   end

   always_comb begin
      value_in     = value_ff;
      has_value_in = has_value_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         value_in     = req_data.element_value[VB-1:0];
         has_value_in = req_data.has_value;
         last_in      = req_data.end_of_sequence;
         lo_in        = '0;
         hi_in        = count_ff;
         pend_in      = 1'b0;
      end

      if (word.search) begin
         lo_in   = lo_n;
         hi_in   = hi_n;
         mid_in  = mid_n;
         pend_in = rd_en;
      end

      if (word.update && append) begin
         if (count_ff != lis_pkg::MAX_CNT) begin
            count_in = count_ff + CB'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (respond) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.run_length      = lis_pkg::len_sat(count_ff);
         rsp_data_in.sequence_done   = last_ff;
         rsp_data_in.table_overflow  = overflow_ff;
         if (last_ff) begin
            count_in    = '0;
            overflow_in = 1'b0;
         end
      end
   end

   // tail memory: one access per cycle, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tail_mem[lo_ff[AB-1:0]] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= tail_mem[mid_n[AB-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      has_value_ff <= has_value_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lis_pkg::MAX_CNT)
      else $error("tail count above table size");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("pending probe outside search window");

   a_read_valid_tail: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> mid_n < count_ff)
      else $error("read of a tail beyond the count");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      respond && last_ff |=> count_ff == '0 && !overflow_ff)
      else $error("table not cleared after end of sequence");

endmodule

### src/lis_seq.sv
module lis_seq (
   input  logic                clock,
   input  logic                reset,
   input  lis_pkg::flags_type  flags,
   output lis_pkg::ucode_type  word
);

   lis_pkg::step_type step_ff;
   lis_pkg::step_type step_in;
   logic              cond_true;

   // control word for the current step
   always_comb begin
      word = lis_pkg::ucode_rom(step_ff);
   end

   always_comb begin
      unique case (word.cond)
         lis_pkg::COND_ALWAYS:      cond_true = 1'b1;
         lis_pkg::COND_REQ:         cond_true = flags.req_valid;
         lis_pkg::COND_HAS_VALUE:   cond_true = flags.has_value;
         lis_pkg::COND_SEARCH_DONE: cond_true = flags.search_done;
         lis_pkg::COND_RSP_FREE:    cond_true = flags.rsp_free;
         default:                   cond_true = 1'b1;
      endcase
      step_in = cond_true ? word.jump : word.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lis_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
